### hdl/lfulru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfulru_pkg
// Shared types and constants of the LFU replacement block with LRU tie-break.
// ----------------------------------------------------------------------------
package lfulru_pkg;

  // beat field widths
  localparam int MODE_W    = 2;
  localparam int SET_W     = 6;
  localparam int WAY_W     = 3;
  localparam int NOW_W     = 32;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 8;

  // input tdata layout
  localparam int SET_LSB = 0;
  localparam int WAY_LSB = SET_LSB + SET_W;
  localparam int NOW_LSB = WAY_LSB + WAY_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INVAL  = 2'd0,
    MODE_TOUCH  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### hdl/lfulru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfulru_ctrl
// Sequencer: clearing pass after reset, then accept / execute per item.
// ----------------------------------------------------------------------------
module lfulru_ctrl
  import lfulru_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_tvalid_i,
  output logic         s_tready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
      end
      ST_EXEC: begin
        // hold the result until the output register can take it
        cmd_o.commit = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  a_no_commit_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.commit && cmd_o.clear_step))
    else $error("commit during clearing pass");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_EXEC)
    else $error("accepted beat not executed");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !status_i.out_free) |=> state_q == ST_EXEC)
    else $error("result dropped while output stalled");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && status_i.clear_last) |=> state_q == ST_IDLE)
    else $error("clearing pass did not finish");

endmodule
`default_nettype wire

### hdl/lfulru_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfulru_dp
// Set-row memory, way update, victim compare tree and output register.
// ----------------------------------------------------------------------------
module lfulru_dp
  import lfulru_pkg::*;
#(
  parameter int WAYS       = 8,
  parameter int SETS       = 64,
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire cmd_t           cmd_i,
  output status_t             status_o,
  input  wire [MODE_W-1:0]    mode_i,
  input  wire [SET_W-1:0]     set_index_i,
  input  wire [WAY_W-1:0]     way_i,
  input  wire [NOW_W-1:0]     now_i,
  input  wire                 m_tready_i,
  output logic                m_tvalid_o,
  output logic [WAY_W-1:0]    victim_way_o,
  output logic                victim_valid_o
);

  localparam int WAY_AW = $clog2(WAYS);
  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ENT_W  = COUNT_BITS + TIME_BITS;
  localparam int ROW_W  = WAYS * ENT_W;
  localparam int LEAVES = 1 << WAY_AW;

  typedef struct packed {
    logic                  vld;
    logic [WAY_AW-1:0]     idx;
    logic [COUNT_BITS-1:0] cnt;
    logic [TIME_BITS-1:0]  tim;
  } node_t;

  // one row per set, each way slot is {count, time}
  logic [ROW_W-1:0]  mem_q [SETS];
  logic [ROW_W-1:0]  rd_row_q;
  logic [SET_AW-1:0] clr_cnt_q;

  mode_e                mode_q;
  logic                 set_ok_q;
  logic                 way_ok_q;
  logic [SET_AW-1:0]    addr_q;
  logic [WAY_AW-1:0]    way_q;
  logic [TIME_BITS-1:0] now_q;

  logic                 out_valid_q;
  logic [WAY_W-1:0]     out_way_q;
  logic                 out_flag_q;

  logic [ROW_W-1:0]         new_row;
  logic [ENT_W-1:0]         old_ent;
  logic [ENT_W-1:0]         new_ent;
  logic [COUNT_BITS-1:0]    old_cnt;
  logic                     wr_en;
  logic [LEAVES*ENT_W-1:0]  row_ext;
  node_t                    node [2*LEAVES];
  logic [WAY_AW-1:0]        best;

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clear_last = (clr_cnt_q == SET_AW'(SETS - 1));
  assign status_o.out_free   = !out_valid_q || m_tready_i;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_e'(mode_i);
      set_ok_q <= (32'(set_index_i) < SETS);
      way_ok_q <= (32'(way_i) < WAYS);
      addr_q   <= SET_AW'(set_index_i);
      way_q    <= WAY_AW'(way_i);
      now_q    <= TIME_BITS'(now_i);
    end
  end

  // row memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      mem_q[addr_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_row_q <= mem_q[SET_AW'(set_index_i)];
    end
  end

  // way update
  always_comb begin
    old_ent = rd_row_q[way_q*ENT_W +: ENT_W];
    old_cnt = old_ent[ENT_W-1 -: COUNT_BITS];
    new_ent = old_ent;
    unique case (mode_q)
      MODE_INVAL:  new_ent = '0;
      MODE_TOUCH: begin
        new_ent = {(old_cnt == {COUNT_BITS{1'b1}}) ? old_cnt : old_cnt + 1'b1, now_q};
      end
      MODE_INSERT: new_ent = {COUNT_BITS'(1), now_q};
      MODE_QUERY:  new_ent = old_ent;
      default:     new_ent = old_ent;
    endcase
    new_row = rd_row_q;
    new_row[way_q*ENT_W +: ENT_W] = new_ent;
  end

  assign wr_en = cmd_i.commit && (mode_q != MODE_QUERY) && set_ok_q && way_ok_q;

  // victim tree: lower count wins, then older time, then lower way
  always_comb begin
    logic pick_r;
    row_ext = '0;
    row_ext[ROW_W-1:0] = rd_row_q;
    pick_r = 1'b0;
    for (int i = 0; i < LEAVES; i++) begin
      node[LEAVES+i].vld = (i < WAYS);
      node[LEAVES+i].idx = WAY_AW'(i);
      node[LEAVES+i].cnt = row_ext[i*ENT_W+TIME_BITS +: COUNT_BITS];
      node[LEAVES+i].tim = row_ext[i*ENT_W +: TIME_BITS];
    end
    node[0] = '0;
    for (int i = LEAVES - 1; i >= 1; i--) begin
      pick_r = node[2*i+1].vld && (!node[2*i].vld ||
               (node[2*i+1].cnt < node[2*i].cnt) ||
               ((node[2*i+1].cnt == node[2*i].cnt) && (node[2*i+1].tim < node[2*i].tim)));
      node[i] = pick_r ? node[2*i+1] : node[2*i];
    end
    best = node[1].idx;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_flag_q <= (mode_q == MODE_QUERY);
      out_way_q  <= ((mode_q == MODE_QUERY) && set_ok_q) ? WAY_W'(best) : '0;
    end
  end

  assign m_tvalid_o     = out_valid_q;
  assign victim_way_o   = out_way_q;
  assign victim_valid_o = out_flag_q;

endmodule
`default_nettype wire

### hdl/lfu_lru_tiebreak_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat's row is read into a register; in the execute state the item
// is updated and compared and its result goes into the output register. tready
// stays low through this read-modify-write of one set row, so a new beat is taken
// only after the last one commits. A stalled output holds the item in its
// execute state until the register frees. Reset: a clearing pass zeroes the row
// memory set by set; tready stays low until it finishes.
// ----------------------------------------------------------------------------
// lfu_lru_tiebreak_replacement
// LFU replacement state with LRU tie-break: per-way counts and touch times.
// ----------------------------------------------------------------------------
module lfu_lru_tiebreak_replacement
  import lfulru_pkg::*;
#(
  parameter int WAYS       = 8,
  parameter int SETS       = 64,
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire [S_TDATA_W-1:0]  s_axis_tdata_i,  // set_index[5:0], way[8:6], now[40:9]
  input  wire [MODE_W-1:0]     s_axis_tuser_i,  // mode[1:0]
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // victim_way[2:0]
  output logic                 m_axis_tuser_o   // victim_valid[0]
);

  cmd_t             cmd;
  status_t          status;
  logic [WAY_W-1:0] victim_way;

  lfulru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfulru_dp #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (s_axis_tuser_i),
    .set_index_i    (s_axis_tdata_i[SET_LSB +: SET_W]),
    .way_i          (s_axis_tdata_i[WAY_LSB +: WAY_W]),
    .now_i          (s_axis_tdata_i[NOW_LSB +: NOW_W]),
    .m_tready_i     (m_axis_tready_i),
    .m_tvalid_o     (m_axis_tvalid_o),
    .victim_way_o   (victim_way),
    .victim_valid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = M_TDATA_W'(victim_way);

endmodule
`default_nettype wire

### dv/tb_lfu_lru_tiebreak_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_lru_tiebreak_replacement
// Self-checking bench for the LFU replacement block with LRU tie-break. A
// scoreboard mirrors the per-way counts and touch times, predicts the answer
// of every accepted beat and compares it with the output stream in order.
// Directed beats cover empty sets, full ties, the older-time tie-break and
// count ordering. Random traffic follows on a few hot sets, with random
// back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_lfu_lru_tiebreak_replacement;
  import lfulru_pkg::*;

  localparam int NUM_WAYS   = 8;
  localparam int NUM_SETS   = 64;
  localparam int HANG_LIMIT = 4000;

  typedef struct {
    logic [WAY_W-1:0] way;
    logic             valid;
  } answer_t;

  class victim_scoreboard;
    logic [15:0]      hits  [NUM_SETS][NUM_WAYS];
    logic [NOW_W-1:0] stamp [NUM_SETS][NUM_WAYS];
    answer_t          pending_answers[$];
    int unsigned      errors;

    function new();
      foreach (hits[s, w]) begin
        hits[s][w]  = '0;
        stamp[s][w] = '0;
      end
      errors = 0;
    endfunction

    // lowest count wins, then older stamp, then lowest way
    function logic [WAY_W-1:0] coldest_way(logic [SET_W-1:0] set_idx);
      logic [WAY_W-1:0] best;
      best = '0;
      for (int w = 1; w < NUM_WAYS; w++) begin
        if (hits[set_idx][w] < hits[set_idx][best] ||
            (hits[set_idx][w] == hits[set_idx][best] &&
             stamp[set_idx][w] < stamp[set_idx][best]))
          best = w[WAY_W-1:0];
      end
      return best;
    endfunction

    function void note_access(mode_e mode, logic [SET_W-1:0] set_idx,
                              logic [WAY_W-1:0] way, logic [NOW_W-1:0] now);
      answer_t ans;
      ans.way   = '0;
      ans.valid = 1'b0;
      case (mode)
        MODE_INVAL: begin
          hits[set_idx][way]  = '0;
          stamp[set_idx][way] = '0;
        end
        MODE_TOUCH: begin
          if (hits[set_idx][way] != 16'hffff) hits[set_idx][way] = hits[set_idx][way] + 16'd1;
          stamp[set_idx][way] = now;
        end
        MODE_INSERT: begin
          hits[set_idx][way]  = 16'd1;
          stamp[set_idx][way] = now;
        end
        default: begin
          ans.way   = coldest_way(set_idx);
          ans.valid = 1'b1;
        end
      endcase
      pending_answers.push_back(ans);
    endfunction

    function void check_answer(logic [M_TDATA_W-1:0] tdata, logic tuser);
      answer_t ans;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: tdata=%0h tuser=%0b", tdata, tuser);
        return;
      end
      ans = pending_answers.pop_front();
      if (tdata != M_TDATA_W'(ans.way) || tuser != ans.valid) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: victim_way exp %0d got %0d, victim_valid exp %0b got %0b",
                   $realtime, ans.way, tdata, ans.valid, tuser);
      end
    endfunction
  endclass

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [MODE_W-1:0]    s_tuser  = '0;
  logic                 m_tready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  victim_scoreboard sb = new();
  bit               calm = 1'b0;
  int unsigned      quiet_cycles = 0;
  logic [NOW_W-1:0] clock_now = '0;

  lfu_lru_tiebreak_replacement u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready_o)
      sb.note_access(mode_e'(s_tuser), s_tdata[SET_LSB +: SET_W], s_tdata[WAY_LSB +: WAY_W],
                     s_tdata[NOW_LSB +: NOW_W]);
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_answer(m_axis_tdata_o, m_axis_tuser_o);
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", HANG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_access(input mode_e mode, input logic [SET_W-1:0] set_idx,
                             input logic [WAY_W-1:0] way, input logic [NOW_W-1:0] now);
    while (!calm && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= S_TDATA_W'({now, way, set_idx});
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  initial begin
    int unsigned pick;
    mode_e       mode;
    logic [SET_W-1:0] set_idx;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty sets answer way 0
    send_access(MODE_QUERY, 6'd0, 3'd5, 32'd0);
    send_access(MODE_QUERY, 6'd63, 3'd7, 32'hffff_ffff);
    send_access(MODE_INSERT, 6'd63, 3'd0, 32'd5);
    send_access(MODE_QUERY, 6'd63, 3'd0, 32'd5);
    send_access(MODE_TOUCH, 6'd63, 3'd7, 32'hffff_ffff);
    send_access(MODE_INVAL, 6'd63, 3'd7, 32'h1234_5678);
    send_access(MODE_QUERY, 6'd63, 3'd2, 32'h1234_5678);
    // full set at count one: older stamp decides, equal stamps go to the lower way
    send_access(MODE_INSERT, 6'd2, 3'd0, 32'd100);
    send_access(MODE_INSERT, 6'd2, 3'd1, 32'd50);
    send_access(MODE_INSERT, 6'd2, 3'd2, 32'd50);
    send_access(MODE_INSERT, 6'd2, 3'd3, 32'd200);
    send_access(MODE_INSERT, 6'd2, 3'd4, 32'd200);
    send_access(MODE_INSERT, 6'd2, 3'd5, 32'd300);
    send_access(MODE_INSERT, 6'd2, 3'd6, 32'hffff_ffff);
    send_access(MODE_INSERT, 6'd2, 3'd7, 32'h8000_0000);
    send_access(MODE_QUERY, 6'd2, 3'd0, 32'h8000_0000);
    send_access(MODE_TOUCH, 6'd2, 3'd1, 32'h8000_0000);
    send_access(MODE_QUERY, 6'd2, 3'd0, 32'h8000_0000);
    send_access(MODE_TOUCH, 6'd2, 3'd2, 32'h8000_0001);
    send_access(MODE_QUERY, 6'd2, 3'd7, 32'h8000_0001);
    send_access(MODE_INVAL, 6'd2, 3'd6, 32'h8000_0001);
    send_access(MODE_QUERY, 6'd2, 3'd1, 32'h8000_0001);

    // a way touched several times outranks freshly inserted ones
    for (int i = 0; i < 6; i++) send_access(MODE_TOUCH, 6'd10, 3'd6, 32'(i));
    for (int w = 0; w < NUM_WAYS; w++)
      if (w != 6) send_access(MODE_INSERT, 6'd10, 3'(w), 32'd70000 + 32'(w));
    send_access(MODE_QUERY, 6'd10, 3'd0, 32'd70010);
    send_access(MODE_TOUCH, 6'd10, 3'd6, 32'd70011);
    send_access(MODE_QUERY, 6'd10, 3'd0, 32'd70011);

    // random traffic, mostly on a few hot sets so counts and stamps collide
    clock_now = 32'd80000;
    for (int n = 0; n < 1300; n++) begin
      calm = (n >= 500 && n < 800);
      pick = $urandom_range(99);
      if (pick < 10)      mode = MODE_INVAL;
      else if (pick < 45) mode = MODE_TOUCH;
      else if (pick < 65) mode = MODE_INSERT;
      else                mode = MODE_QUERY;
      set_idx = ($urandom_range(99) < 70) ? SET_W'($urandom_range(3)) : SET_W'($urandom());
      if ($urandom_range(99) < 3) clock_now = $urandom();
      else clock_now = clock_now + NOW_W'($urandom_range(2));
      send_access(mode, set_idx, WAY_W'($urandom()), clock_now);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
